// ===== rtl/acrp_pkg.sv =====
// ----------------------------------------------------------------------------
// acrp_pkg
// Shared types, codes and the header character decoder of the ASCII command
// register parser.
// ----------------------------------------------------------------------------
package acrp_pkg;

  localparam int TGT_BITS = 5;
  localparam int CNT_BITS = 7;
  localparam int TMO_BITS = 16;
  localparam int MS_BITS  = 17;
  localparam int OUT_BITS = 32;

  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic CFG_TIMEOUT    = 1'b0;
  localparam logic CFG_CHAR_LIMIT = 1'b1;

  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [TGT_BITS-1:0] IDX_STATUS = 5'd7;
  localparam logic [TGT_BITS-1:0] IDX_POWER  = 5'd8;

  localparam logic [TMO_BITS-1:0] TIMEOUT_RESET    = 16'd500;
  localparam logic [CNT_BITS-1:0] CHAR_LIMIT_RESET = 7'd16;

  typedef enum logic [0:0] {
    PKT_IDLE,
    PKT_BODY
  } pkt_state_t;

  typedef struct packed {
    logic                wr_en;
    logic [TGT_BITS-1:0] wr_idx;
    logic                tmo_clr;
    logic                rd_en;
    logic [TGT_BITS-1:0] rd_idx;
  } mem_ctl_t;

  typedef struct packed {
    logic                write_valid;
    logic [TGT_BITS-1:0] target;
    logic                status_flag;
    logic                power_flag;
    logic                timed_out;
    logic                overflow_error;
    logic                abort_error;
    logic                is_read;
  } res_t;

  typedef struct packed {
    logic                hit;
    logic [TGT_BITS-1:0] idx;
  } hdr_t;

  function automatic hdr_t header_lookup(input logic [7:0] b);
    hdr_t h;
    h.hit = 1'b1;
    h.idx = '0;
    case (b)
      8'h58: h.idx = 5'd0;
      8'h59: h.idx = 5'd1;
      8'h41: h.idx = 5'd2;
      8'h4C: h.idx = 5'd3;
      8'h52: h.idx = 5'd4;
      8'h54: h.idx = 5'd5;
      8'h56: h.idx = 5'd6;
      8'h53: h.idx = 5'd7;
      8'h55: h.idx = 5'd8;
      8'h7B: h.idx = 5'd9;
      8'h7D: h.idx = 5'd10;
      8'h5E: h.idx = 5'd11;
      8'h3D: h.idx = 5'd12;
      8'h28: h.idx = 5'd13;
      8'h29: h.idx = 5'd14;
      8'h5F: h.idx = 5'd15;
      8'h7C: h.idx = 5'd16;
      default: h.hit = 1'b0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/acrp_regfile.sv =====
// ----------------------------------------------------------------------------
// acrp_regfile
// Target value memory with one write and one registered read per cycle.
// Per-entry valid bits give the reset contents and the watchdog clear.
// ----------------------------------------------------------------------------
module acrp_regfile #(
  parameter int NUM_TARGETS = 17,
  parameter int VALUE_BITS  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  acrp_pkg::mem_ctl_t      ctl,
  input  logic [VALUE_BITS-1:0]   wr_data,
  output logic [VALUE_BITS-1:0]   rd_value
);

  localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

  logic [VALUE_BITS-1:0]  mem_r [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] vld_r;
  logic [NUM_TARGETS-1:0] vld_nxt;
  logic [VALUE_BITS-1:0]  rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_inrange_r;
  logic                   rd_power_r;
  logic                   wr_inrange;
  logic                   rd_inrange;

  assign wr_inrange = ({1'b0, ctl.wr_idx} < 6'(NUM_TARGETS));
  assign rd_inrange = ({1'b0, ctl.rd_idx} < 6'(NUM_TARGETS));

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.tmo_clr) begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
        if (i <= int'(acrp_pkg::IDX_POWER)) begin
          vld_nxt[i] = 1'b0;
        end
      end
    end
    if (ctl.wr_en && wr_inrange) begin
      vld_nxt[ctl.wr_idx[IDX_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_inrange) begin
      mem_r[ctl.wr_idx[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r    <= mem_r[ctl.rd_idx[IDX_W-1:0]];
      rd_vld_r     <= vld_r[ctl.rd_idx[IDX_W-1:0]];
      rd_inrange_r <= rd_inrange;
      rd_power_r   <= (ctl.rd_idx == acrp_pkg::IDX_POWER);
    end
  end

  always_comb begin
    if (!rd_inrange_r) begin
      rd_value = '0;
    end else if (rd_vld_r) begin
      rd_value = rd_data_r;
    end else begin
      rd_value = VALUE_BITS'(rd_power_r);
    end
  end

endmodule

// ===== rtl/acrp_parser.sv =====
// ----------------------------------------------------------------------------
// acrp_parser
// Packet state machine, digit accumulator, watchdog counter and the status
// and power flags. Drives the memory write and read requests.
// ----------------------------------------------------------------------------
module acrp_parser #(
  parameter int NUM_TARGETS = 17,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [1:0]                        func,
  input  logic [7:0]                        rx_byte,
  input  logic                              status_value,
  input  logic [acrp_pkg::TGT_BITS-1:0]     read_index,
  input  logic [acrp_pkg::TMO_BITS-1:0]     timeout_limit,
  input  logic [acrp_pkg::CNT_BITS-1:0]     char_limit,
  output acrp_pkg::mem_ctl_t                ctl,
  output logic [VALUE_BITS-1:0]             wr_data,
  output acrp_pkg::res_t                    res,
  output logic [VALUE_BITS-1:0]             res_value
);

  acrp_pkg::pkt_state_t                state_r, state_nxt;
  logic [acrp_pkg::TGT_BITS-1:0]       tgt_r, tgt_nxt;
  logic [acrp_pkg::CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic                                neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]               acc_r, acc_nxt;
  logic [acrp_pkg::MS_BITS-1:0]        ms_r, ms_nxt;
  logic                                status_r, status_nxt;
  logic                                power_r, power_nxt;
  acrp_pkg::hdr_t                      hdr;
  logic [VALUE_BITS-1:0]               wv;

  assign hdr = acrp_pkg::header_lookup(rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= acrp_pkg::PKT_IDLE;
      tgt_r    <= '0;
      cnt_r    <= '0;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      ms_r     <= '0;
      status_r <= 1'b0;
      power_r  <= 1'b1;
    end else if (accept) begin
      state_r  <= state_nxt;
      tgt_r    <= tgt_nxt;
      cnt_r    <= cnt_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      ms_r     <= ms_nxt;
      status_r <= status_nxt;
      power_r  <= power_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    tgt_nxt    = tgt_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    ms_nxt     = ms_r;
    status_nxt = status_r;
    power_nxt  = power_r;
    ctl        = '0;
    wr_data    = '0;
    res        = '0;
    res_value  = '0;
    wv         = neg_r ? ('0 - acc_r) : acc_r;
    if (tgt_r == acrp_pkg::IDX_STATUS) begin
      wv = VALUE_BITS'(1'b1);
    end else if (tgt_r == acrp_pkg::IDX_POWER) begin
      wv = VALUE_BITS'(|wv);
    end
    case (func)
      acrp_pkg::FUNC_BYTE: begin
        case (state_r)
          acrp_pkg::PKT_IDLE: begin
            if (hdr.hit && ({1'b0, hdr.idx} < 6'(NUM_TARGETS))) begin
              state_nxt = acrp_pkg::PKT_BODY;
              tgt_nxt   = hdr.idx;
            end
          end
          acrp_pkg::PKT_BODY: begin
            if (cnt_r >= char_limit) begin
              state_nxt = acrp_pkg::PKT_IDLE;
              res.overflow_error = 1'b1;
            end else if (rx_byte >= acrp_pkg::CH_SLASH && rx_byte < acrp_pkg::CH_COLON) begin
              cnt_nxt = cnt_r + 7'd1;
              if (rx_byte >= acrp_pkg::CH_ZERO) begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) + VALUE_BITS'(rx_byte[3:0]);
              end
            end else if (rx_byte == acrp_pkg::CH_BANG) begin
              state_nxt       = acrp_pkg::PKT_IDLE;
              ms_nxt          = '0;
              ctl.wr_en       = 1'b1;
              ctl.wr_idx      = tgt_r;
              wr_data         = wv;
              res.write_valid = 1'b1;
              res.target      = tgt_r;
              res_value       = wv;
              if (tgt_r == acrp_pkg::IDX_STATUS) begin
                status_nxt = 1'b1;
              end else if (tgt_r == acrp_pkg::IDX_POWER) begin
                power_nxt = |wv;
              end
            end else if (rx_byte == acrp_pkg::CH_MINUS) begin
              neg_nxt = 1'b1;
            end else begin
              state_nxt = acrp_pkg::PKT_IDLE;
              res.abort_error = 1'b1;
            end
          end
          default: begin
            state_nxt = acrp_pkg::PKT_IDLE;
          end
        endcase
        if (state_nxt == acrp_pkg::PKT_IDLE) begin
          if (state_r == acrp_pkg::PKT_BODY) begin
            tgt_nxt = '0;
          end
          cnt_nxt = '0;
          neg_nxt = 1'b0;
          acc_nxt = '0;
        end
      end
      acrp_pkg::FUNC_TICK: begin
        if (!(&ms_r)) begin
          ms_nxt = ms_r + 17'd1;
        end
        if (ms_nxt > {1'b0, timeout_limit}) begin
          status_nxt    = 1'b0;
          power_nxt     = 1'b1;
          ctl.tmo_clr   = 1'b1;
          res.timed_out = 1'b1;
        end
      end
      acrp_pkg::FUNC_STATUS: begin
        status_nxt = status_value;
        ctl.wr_en  = 1'b1;
        ctl.wr_idx = acrp_pkg::IDX_STATUS;
        wr_data    = VALUE_BITS'(status_value);
      end
      acrp_pkg::FUNC_READ: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_idx  = read_index;
        res.target  = read_index;
        res.is_read = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
    res.status_flag = status_nxt;
    res.power_flag  = power_nxt;
  end

endmodule

// ===== rtl/ascii_command_register_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_command_register_parser
// Parses ASCII command packets into a bank of target value registers, with
// a millisecond watchdog, a status flag and a power flag.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    func, rx_byte, status_value,
//                                               read_index
//   out_      output     out_valid / out_ready  write_valid, target, value,
//                                               flags and error bits
//   cfg_      input      cfg_we                 cfg_index, cfg_data
//
// Every item makes at most one memory access, so items can follow back to
// back. The result is registered and appears in the cycle after its item
// is accepted; a read takes its data from the memory read register at that
// point. Reset is synchronous and needs no clearing pass. While a result
// waits with out_ready low, it holds and in_ready is low.
// ----------------------------------------------------------------------------
module ascii_command_register_parser #(
  parameter int NUM_TARGETS = 17,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_func,
  input  logic [7:0]                          in_rx_byte,
  input  logic                                in_status_value,
  input  logic [acrp_pkg::TGT_BITS-1:0]       in_read_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_valid,
  output logic [acrp_pkg::TGT_BITS-1:0]       out_target,
  output logic signed [acrp_pkg::OUT_BITS-1:0] out_value,
  output logic                                out_status_flag,
  output logic                                out_power_flag,
  output logic                                out_timed_out,
  output logic                                out_overflow_error,
  output logic                                out_abort_error,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [acrp_pkg::TMO_BITS-1:0]       cfg_data
);

  logic                                accept;
  logic                                out_valid_r;
  acrp_pkg::res_t                      res_r;
  logic [acrp_pkg::OUT_BITS-1:0]       val_r;
  logic [acrp_pkg::TMO_BITS-1:0]       timeout_limit_r;
  logic [acrp_pkg::CNT_BITS-1:0]       char_limit_r;
  acrp_pkg::mem_ctl_t                  ctl;
  acrp_pkg::res_t                      res;
  logic [VALUE_BITS-1:0]               wr_data;
  logic [VALUE_BITS-1:0]               res_value;
  logic [VALUE_BITS-1:0]               rd_value;
  logic [63:0]                         res_wide;
  logic [63:0]                         rd_wide;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= acrp_pkg::TIMEOUT_RESET;
      char_limit_r    <= acrp_pkg::CHAR_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        acrp_pkg::CFG_TIMEOUT:    timeout_limit_r <= cfg_data;
        acrp_pkg::CFG_CHAR_LIMIT: char_limit_r    <= cfg_data[acrp_pkg::CNT_BITS-1:0];
        default:                  timeout_limit_r <= timeout_limit_r;
      endcase
    end
  end

  acrp_parser #(
    .NUM_TARGETS (NUM_TARGETS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .func          (in_func),
    .rx_byte       (in_rx_byte),
    .status_value  (in_status_value),
    .read_index    (in_read_index),
    .timeout_limit (timeout_limit_r),
    .char_limit    (char_limit_r),
    .ctl           (ctl),
    .wr_data       (wr_data),
    .res           (res),
    .res_value     (res_value)
  );

  acrp_regfile #(
    .NUM_TARGETS (NUM_TARGETS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (accept ? ctl : acrp_pkg::mem_ctl_t'('0)),
    .wr_data  (wr_data),
    .rd_value (rd_value)
  );

  assign res_wide = 64'(res_value);
  assign rd_wide  = 64'(rd_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
      val_r <= res_wide[acrp_pkg::OUT_BITS-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_valid    = res_r.write_valid;
  assign out_target         = res_r.target;
  assign out_value          = res_r.is_read ? rd_wide[acrp_pkg::OUT_BITS-1:0] : val_r;
  assign out_status_flag    = res_r.status_flag;
  assign out_power_flag     = res_r.power_flag;
  assign out_timed_out      = res_r.timed_out;
  assign out_overflow_error = res_r.overflow_error;
  assign out_abort_error    = res_r.abort_error;

endmodule

// ===== rtl/acrp_checker.sv =====
// ----------------------------------------------------------------------------
// acrp_checker
// Port-level checks of the ASCII command register parser, bound to the top.
// ----------------------------------------------------------------------------
module acrp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_write_valid,
  input logic [acrp_pkg::TGT_BITS-1:0]        out_target,
  input logic signed [acrp_pkg::OUT_BITS-1:0] out_value,
  input logic                                 out_status_flag,
  input logic                                 out_power_flag,
  input logic                                 out_timed_out,
  input logic                                 out_overflow_error,
  input logic                                 out_abort_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_target)
      && $stable(out_write_valid))
    else $error("result changed while stalled");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_write_valid, out_timed_out, out_overflow_error,
      out_abort_error}) <= 1)
    else $error("more than one event flag in one item");

  a_timeout_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> !out_status_flag && out_power_flag)
    else $error("watchdog expiry left status set or power off");

  a_status_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && out_target == acrp_pkg::IDX_STATUS
      |-> out_status_flag && out_value == 32'sd1)
    else $error("status write did not store one");

  a_power_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && out_target == acrp_pkg::IDX_POWER
      |-> out_power_flag == (out_value != 32'sd0))
    else $error("power flag disagrees with written value");

endmodule

bind ascii_command_register_parser acrp_checker u_acrp_checker (.*);
